[src/ipv4_tcp_internet_checksum_assert.svh]
// Assertion macros shared by the internet checksum RTL.
`ifndef IPV4_TCP_INTERNET_CHECKSUM_ASSERT_SVH
`define IPV4_TCP_INTERNET_CHECKSUM_ASSERT_SVH

// Clocked assertion on clk_i, off while rst_ni is low.
`define ITC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication form: when cond holds at an edge, check holds at the next one.
`define ITC_ASSERT_NEXT(label, cond, check, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (cond) |=> (check)) else $error(msg);

`endif

[src/itc_pkg.sv]
// Types and constants of the IPv4 / TCP internet checksum block.
`default_nettype none
package itc_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       mode;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [15:0] checksum;
    logic        short_packet;
  } out_item_t;

  localparam logic [15:0] TcpProtoWord = 16'h0006;
  localparam logic [15:0] PseudoStart  = 16'd8;
  localparam logic [15:0] LenWordOff   = 16'd10;
  localparam logic [15:0] PosMax       = 16'hFFFF;
  localparam logic [15:0] MinTcpBytes  = 16'd4;
  localparam logic [15:0] LenHiPos     = 16'd2;
  localparam logic [15:0] LenLoPos     = 16'd3;

endpackage
`default_nettype wire

[src/itc_word_gate.sv]
// Coverage and pseudo-header substitution for one 16-bit word.
`default_nettype none
module itc_word_gate #(
  parameter int IP_HEADER_BYTES = 20
) (
  input  logic [15:0] off_i,
  input  logic [15:0] word_i,
  input  logic        tcp_i,
  input  logic [15:0] plen_i,
  output logic [15:0] word_o
);
  import itc_pkg::*;

  localparam logic [15:0] HdrLen = 16'(IP_HEADER_BYTES);

  logic [16:0] plen_inc;
  logic [15:0] half_words;
  logic        covered;

  // padded length / 2; offsets are even so compare word indexes
  assign plen_inc   = {1'b0, plen_i} + 17'd1;
  assign half_words = plen_inc[16:1];

  always_comb begin
    if (!tcp_i) begin
      covered = off_i < HdrLen;
    end else begin
      covered = (off_i >= PseudoStart) && ({1'b0, off_i[15:1]} < half_words);
    end
    if (!covered) begin
      word_o = '0;
    end else if (tcp_i && off_i == PseudoStart) begin
      word_o = TcpProtoWord;
    end else if (tcp_i && off_i == LenWordOff) begin
      word_o = plen_i - HdrLen;
    end else begin
      word_o = word_i;
    end
  end

endmodule
`default_nettype wire

[src/ipv4_tcp_internet_checksum.sv]
// Top level of the IPv4 header / TCP internet checksum block.
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_item_i) takes one packet byte per item,
//   starting at the first IP header byte. mode is sampled on the first byte: 0 sums the
//   IP header words, 1 sums the TCP segment plus pseudo-header (protocol and TCP length
//   are inserted at offsets 8 and 10). last marks the final byte of the packet.
//   Output channel (out_valid_o / out_stall_i / out_item_o) carries one item per packet:
//   the inverted ones'-complement sum and a flag for a packet shorter than needed.
// Timing:
//   An accepted byte sits in the input register, then a single add with
//   end-around carry (up to three extra words on the last byte) updates the state.
//   The result enters the output register as the last byte leaves the input register.
//   Throughput is one byte per cycle, packets back to back with no gap, unless a last byte is held by a stalled result.
// Reset: clears the byte position and both valid flags; the block waits for a new packet.
// Backpressure: while a result waits in the output register under stall, non-last bytes
//   keep flowing; a last byte holds in the input register, and in_stall_o rises only
//   once that register is occupied by such a blocked byte.
`default_nettype none
module ipv4_tcp_internet_checksum #(
  parameter int IP_HEADER_BYTES = 20
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  itc_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output itc_pkg::out_item_t out_item_o
);
  import itc_pkg::*;

  localparam logic [15:0] HdrLen = 16'(IP_HEADER_BYTES);

  // input register
  logic      in_valid_q;
  in_item_t  in_q;
  logic      advance;

  // packet state
  logic [15:0] pos_q, pos_d;
  logic [15:0] plen_q, plen_d;
  logic [15:0] sum_q, sum_d;
  logic [7:0]  pend_q, pend_d;
  logic        mode_q, mode_d;

  // output register
  logic      out_valid_q;
  out_item_t out_q, out_d;

  // datapath
  logic        first, active, tcp;
  logic [15:0] plen_base, sum_base;
  logic        take_data;
  logic [15:0] data_off, data_raw;
  logic [15:0] w_data, w_proto, w_len;
  logic [15:0] w0, w1, w2;
  logic [17:0] sum_raw;
  logic [16:0] fold1;
  logic        short_pkt;

  // a last byte needs room in the output register; others always drain
  assign advance    = in_valid_q && (!in_q.last || !out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_item_i;
    end
  end

  // --- per-byte update ---
  assign first     = pos_q == '0;
  assign active    = pos_q != PosMax;
  assign tcp       = first ? in_q.mode : mode_q;
  assign plen_base = first ? '0 : plen_q;
  assign sum_base  = first ? '0 : sum_q;

  always_comb begin
    plen_d = plen_base;
    if (active && pos_q == LenHiPos) begin
      plen_d = {in_q.data_byte, plen_base[7:0]};
    end else if (active && pos_q == LenLoPos) begin
      plen_d = {plen_base[15:8], in_q.data_byte};
    end
  end

  assign pend_d = (active && !pos_q[0]) ? in_q.data_byte : pend_q;
  assign pos_d  = active ? pos_q + 16'd1 : pos_q;
  assign mode_d = tcp;

  // A word completes on an odd byte; on the last byte an odd count pads with zero.
  // Either way the word sits at the even offset just at or below this byte.
  assign take_data = (active && pos_q[0]) || in_q.last;
  assign data_off  = {pos_q[15:1], 1'b0};
  assign data_raw  = (active && pos_q[0]) ? {pend_q, in_q.data_byte} : {pend_d, 8'h00};

  itc_word_gate #(.IP_HEADER_BYTES(IP_HEADER_BYTES)) u_gate_data (
    .off_i  (data_off),
    .word_i (data_raw),
    .tcp_i  (tcp),
    .plen_i (plen_d),
    .word_o (w_data)
  );

  // pseudo-header words the packet ended before reaching
  itc_word_gate #(.IP_HEADER_BYTES(IP_HEADER_BYTES)) u_gate_proto (
    .off_i  (PseudoStart),
    .word_i (16'h0000),
    .tcp_i  (tcp),
    .plen_i (plen_d),
    .word_o (w_proto)
  );

  itc_word_gate #(.IP_HEADER_BYTES(IP_HEADER_BYTES)) u_gate_len (
    .off_i  (LenWordOff),
    .word_i (16'h0000),
    .tcp_i  (tcp),
    .plen_i (plen_d),
    .word_o (w_len)
  );

  assign w0 = take_data ? w_data : '0;
  assign w1 = (in_q.last && tcp && pos_d <= PseudoStart) ? w_proto : '0;
  assign w2 = (in_q.last && tcp && pos_d <= LenWordOff)  ? w_len   : '0;

  // ones'-complement add: the result is order independent, so sum all and fold twice
  assign sum_raw = 18'(sum_base) + 18'(w0) + 18'(w1) + 18'(w2);
  assign fold1   = 17'(sum_raw[15:0]) + 17'(sum_raw[17:16]);
  assign sum_d   = fold1[15:0] + 16'(fold1[16]);

  assign short_pkt = tcp ? ((pos_d < MinTcpBytes) || (pos_d < plen_d)) : (pos_d < HdrLen);

  assign out_d.checksum     = ~sum_d;
  assign out_d.short_packet = short_pkt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      plen_q <= '0;
      sum_q  <= '0;
      pend_q <= '0;
      mode_q <= 1'b0;
    end else if (advance) begin
      if (in_q.last) begin
        pos_q  <= '0;
        plen_q <= '0;
        sum_q  <= '0;
        pend_q <= '0;
        mode_q <= 1'b0;
      end else begin
        pos_q  <= pos_d;
        plen_q <= plen_d;
        sum_q  <= sum_d;
        pend_q <= pend_d;
        mode_q <= mode_d;
      end
    end
  end

  // --- result register ---
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && in_q.last) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_q.last) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `include "ipv4_tcp_internet_checksum_assert.svh"

  `ITC_ASSERT_NEXT(a_pos_cleared_after_last, advance && in_q.last, pos_q == '0, "position not cleared after last byte")
  `ITC_ASSERT_NEXT(a_pos_steps, advance && !in_q.last && pos_q != PosMax, pos_q == $past(pos_q) + 16'd1, "position did not step by one")
  `ITC_ASSERT_NEXT(a_no_spurious_result, !(advance && in_q.last) && (!out_valid_q || !out_stall_i), !out_valid_q, "result without a last byte")
  `ITC_ASSERT_NEXT(a_held_byte_kept, in_valid_q && !advance, in_valid_q && $stable(in_q), "held input byte lost or changed")
  `ITC_ASSERT(a_stall_only_on_last, !in_stall_o || (in_q.last && out_valid_q && out_stall_i), "input stalled without a blocked last byte")

endmodule
`default_nettype wire
